### hw/rtl/vgct_pkg.sv
// ----------------------------------------------------------------------------
// vgct_pkg
// Shared types, codes and constants of the voxel grid color tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package vgct_pkg;

  // Default geometry of the voxel table
  localparam int unsigned DefTableDepth = 4096;
  localparam int unsigned DefMaxProbes  = 8;

  // Hash mixer constants
  localparam logic [63:0] MixGolden = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MixMul1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMul2   = 64'h94d049bb133111eb;

  localparam logic [7:0] ColorMax = 8'd255;

  // Operation codes
  localparam logic [1:0] OpUpdate = 2'd0;
  localparam logic [1:0] OpRead   = 2'd1;
  localparam logic [1:0] OpClear  = 2'd2;

  // Result status codes
  localparam logic [2:0] StSkipped = 3'd0;
  localparam logic [2:0] StBurnIn  = 3'd1;
  localparam logic [2:0] StTracked = 3'd2;
  localparam logic [2:0] StFull    = 3'd3;
  localparam logic [2:0] StRead    = 3'd4;
  localparam logic [2:0] StCleared = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] CfgInvSize  = 3'd0;
  localparam logic [2:0] CfgBurnIn   = 3'd1;
  localparam logic [2:0] CfgMaxStep  = 3'd2;
  localparam logic [2:0] CfgGray     = 3'd3;
  localparam logic [2:0] CfgSkipGray = 3'd4;

  // Configuration reset values
  localparam logic [31:0] RstInvSize = 32'd218453;
  localparam logic [15:0] RstBurnIn  = 16'd1;
  localparam logic [7:0]  RstMaxStep = 8'd1;
  localparam logic [7:0]  RstGray    = 8'd128;

  // Trend codes
  localparam logic [1:0] TrendNone = 2'b00;
  localparam logic [1:0] TrendUp   = 2'b01;
  localparam logic [1:0] TrendDown = 2'b11;

  // One table entry
  typedef struct packed {
    logic             used;
    logic [2:0][31:0] key;
    logic [31:0]      samples;
    logic [2:0][31:0] mpos;
    logic [2:0][15:0] mcol;
    logic [2:0][7:0]  est;
    logic [2:0][7:0]  step;
    logic [2:0][1:0]  trend;
  } entry_t;

  // Tracker state of one color channel
  typedef struct packed {
    logic [7:0] est;
    logic [7:0] step;
    logic [1:0] trend;
  } trk_t;

  // Advance the adaptive step tracker of one channel by one observation
  function automatic trk_t track_ch(logic [7:0] est, logic [7:0] st, logic [1:0] tr,
                                    logic [7:0] obs, logic [7:0] lim);
    trk_t       r;
    logic       up;
    logic [1:0] dc;
    logic [8:0] st1;
    logic [9:0] e;
    r.est   = est;
    r.step  = st;
    r.trend = tr;
    up  = 1'b0;
    dc  = TrendNone;
    st1 = 9'd0;
    e   = 10'd0;
    if (obs != est) begin
      up  = obs > est;
      dc  = up ? TrendUp : TrendDown;
      st1 = {1'b0, st} + 9'd1;
      if (tr == dc) begin
        r.step = (st1 < {1'b0, lim}) ? st1[7:0] : lim;
      end else begin
        r.step = 8'd1;
      end
      r.trend = dc;
      if (up) begin
        e = {2'b00, est} + {2'b00, r.step};
        r.est = (e > {2'b00, ColorMax}) ? ColorMax : e[7:0];
      end else begin
        e = {2'b00, est} - {2'b00, r.step};
        r.est = e[9] ? 8'd0 : e[7:0];
      end
    end else begin
      r.trend = TrendNone;
      if (st > 8'd1) begin
        r.step = st - 8'd1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/voxel_grid_color_tracker.sv
// Sequence: a slot read passes S_RDSLOT and S_RDDATA; a skipped gray word and a clear
//   answer from the idle state, a clear then sweeping the table; an update quantizes, mixes,
//   reduces the hash (serially if TABLE_DEPTH is not a power of two), probes, runs 3 divisions
//   (6 during burn-in) and writes back; a full table answers after MAX_PROBES probes.
// Throughput: one word at a time; busy drops as the result comes out, except after a clear.
// Reset: sweeps the table with busy high. No stall.
// ----------------------------------------------------------------------------
// voxel_grid_color_tracker
// Voxel hash table with running means of position and color and an adaptive
// per-channel color tracker, kept in one synchronous entry memory.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_grid_color_tracker
  import vgct_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefTableDepth,
  parameter int unsigned MAX_PROBES  = DefMaxProbes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  output logic             done_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic [1:0]  op_i,
  input  wire logic [31:0] pos_x_i,
  input  wire logic [31:0] pos_y_i,
  input  wire logic [31:0] pos_z_i,
  input  wire logic [7:0]  red_in_i,
  input  wire logic [7:0]  green_in_i,
  input  wire logic [7:0]  blue_in_i,
  input  wire logic [11:0] slot_i,
  output logic [2:0]       status_o,
  output logic             new_voxel_o,
  output logic             entry_valid_o,
  output logic [31:0]      avg_x_o,
  output logic [31:0]      avg_y_o,
  output logic [31:0]      avg_z_o,
  output logic [7:0]       red_out_o,
  output logic [7:0]       green_out_o,
  output logic [7:0]       blue_out_o,
  output logic [31:0]      samples_o,
  output logic [12:0]      occupied_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PW = $clog2(MAX_PROBES + 1);
  localparam bit DepthPow2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam logic [AW-1:0] LastIdx = AW'(TABLE_DEPTH - 1);
  localparam logic [PW-1:0] LastProbe = PW'(MAX_PROBES - 1);

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_RDSLOT = 13'b0000000000100,
    S_RDDATA = 13'b0000000001000,
    S_QUANT  = 13'b0000000010000,
    S_MIX    = 13'b0000000100000,
    S_MOD    = 13'b0000001000000,
    S_PRD    = 13'b0000010000000,
    S_PCHK   = 13'b0000100000000,
    S_DSET   = 13'b0001000000000,
    S_DIV    = 13'b0010000000000,
    S_DAPP   = 13'b0100000000000,
    S_WRITE  = 13'b1000000000000
  } state_e;

  state_e state_q;

  // Configuration
  logic [31:0] inv_q;
  logic [15:0] burn_q;
  logic [7:0]  maxs_q;
  logic [7:0]  gray_q;
  logic        skipg_q;

  // Latched word
  logic [2:0][31:0] pos_q;
  logic [2:0][7:0]  col_q;
  logic [11:0]      slot_q;

  // Sequencing
  logic [6:0]    cnt_q;
  logic [1:0]    axis_q;
  logic [2:0]    job_q;
  logic [PW-1:0] probe_q;
  logic [AW-1:0] eidx_q;
  logic [AW-1:0] clr_q;
  logic [CW-1:0] total_q;

  // Hash datapath
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;
  logic [2:0][31:0]   key_q;
  logic [63:0]        mv_q, plo_q, hash_q;
  logic [31:0]        pcr_q;
  logic [AW:0]        modr_q;

  // Entry work copy and divider
  entry_t      ent_q, rd_q, fin, seed;
  logic        fresh_q, burnin_q;
  logic [33:0] num_q;
  logic [31:0] rem_q;
  logic        neg_q;

  // Result registers
  logic             done_q, done_d, newv_q, valid_q;
  logic [2:0]       status_q;
  logic [2:0][31:0] avg_q;
  logic [2:0][7:0]  cout_q;
  logic [31:0]      samp_q;

  // Memory
  entry_t        tbl_mem [TABLE_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata;

  // Combinational helpers
  logic [63:0] mix_c, mix_s, mix_f;
  logic [31:0] mix_hi;
  logic [AW:0] mod_t;
  logic [31:0] base_n, n_next, burn_eff, n_cur;
  logic [7:0]  lim;
  logic        gray_hit, slot_ok, keys_eq;
  logic [32:0] dset_d, dset_mag;
  logic [32:0] div_t;
  logic        div_ge;
  logic [33:0] adj;
  logic [16:0] m17;
  logic [17:0] m18;
  logic [7:0]  est_b;
  logic [1:0]  pj, cj;
  trk_t        trk [3];

  assign busy = (state_q != S_IDLE);

  // Multiplier operand select: quantizer or mixer partial products
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mix_c = (cnt_q < 7'd4) ? MixMul1 : MixMul2;
    if (state_q == S_QUANT && cnt_q < 7'd3) begin
      mul_a = {pos_q[2'(cnt_q)][31], pos_q[2'(cnt_q)]};
      mul_b = {1'b0, inv_q};
    end else if (state_q == S_MIX) begin
      case (cnt_q)
        7'd1, 7'd5: begin
          mul_a = {1'b0, mv_q[31:0]};
          mul_b = {1'b0, mix_c[31:0]};
        end
        7'd2, 7'd6: begin
          mul_a = {1'b0, mv_q[31:0]};
          mul_b = {1'b0, mix_c[63:32]};
        end
        7'd3, 7'd7: begin
          mul_a = {1'b0, mv_q[63:32]};
          mul_b = {1'b0, mix_c[31:0]};
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  // Mixer add and xor-shift steps
  always_comb begin
    mix_hi = pcr_q + prod_q[31:0];
    mix_s  = plo_q + {mix_hi, 32'd0};
    mix_f  = mix_s ^ (mix_s >> 31);
  end

  // Misc decode
  always_comb begin
    mod_t    = {modr_q[AW-1:0], hash_q[63]};
    if (mod_t >= (AW+1)'(TABLE_DEPTH)) begin
      mod_t = mod_t - (AW+1)'(TABLE_DEPTH);
    end
    gray_hit = skipg_q && red_in_i == gray_q && green_in_i == gray_q &&
               blue_in_i == gray_q;
    slot_ok  = 32'(slot_q) < TABLE_DEPTH;
    keys_eq  = rd_q.key[0] == key_q[0] && rd_q.key[1] == key_q[1] &&
               rd_q.key[2] == key_q[2];
    base_n   = rd_q.used ? rd_q.samples : 32'd0;
    n_next   = (base_n == 32'hffffffff) ? base_n : base_n + 32'd1;
    burn_eff = (burn_q == 16'd0) ? 32'd1 : {16'd0, burn_q};
    lim      = (maxs_q == 8'd0) ? 8'd1 : maxs_q;
    n_cur    = ent_q.samples;
    pj       = job_q[1:0];
    cj       = 2'(job_q - 3'd3);
  end

  // Work copy of a probed entry: the stored one or a fresh one
  always_comb begin
    seed = rd_q;
    if (!rd_q.used) begin
      seed      = '0;
      seed.used = 1'b1;
      seed.key  = key_q;
      seed.step = {8'd1, 8'd1, 8'd1};
    end
    seed.samples = n_next;
  end

  // Result strobe
  always_comb begin
    done_d = 1'b0;
    if (state_q == S_IDLE && start) begin
      done_d = (op_i == OpClear) || (op_i == OpUpdate && gray_hit);
    end else if (state_q == S_RDDATA || state_q == S_WRITE) begin
      done_d = 1'b1;
    end else if (state_q == S_PCHK) begin
      done_d = rd_q.used && !keys_eq && probe_q == LastProbe;
    end
  end

  // Division setup, step and apply
  always_comb begin
    if (job_q < 3'd3) begin
      dset_d = {pos_q[pj][31], pos_q[pj]} - {ent_q.mpos[pj][31], ent_q.mpos[pj]};
    end else begin
      dset_d = {17'd0, col_q[cj], 8'd0} - {17'd0, ent_q.mcol[cj]};
    end
    dset_mag = dset_d[32] ? (33'd0 - dset_d) : dset_d;
    div_t    = {rem_q, num_q[33]};
    div_ge   = div_t >= {1'b0, n_cur};
    adj      = neg_q ? (34'd0 - num_q) : num_q;
    m17      = {1'b0, ent_q.mcol[cj]} + adj[16:0];
    m18      = {1'b0, m17} + 18'd128;
    est_b    = (m18[17:8] > 10'd255) ? ColorMax : m18[15:8];
  end

  // Final entry: tracked channels after burn-in
  always_comb begin
    fin = ent_q;
    for (int i = 0; i < 3; i++) begin
      trk[i] = track_ch(ent_q.est[i], ent_q.step[i], ent_q.trend[i], col_q[i], lim);
      if (!burnin_q) begin
        fin.est[i]   = trk[i].est;
        fin.step[i]  = trk[i].step;
        fin.trend[i] = trk[i].trend;
      end
    end
  end

  // Memory port control
  always_comb begin
    mem_we    = (state_q == S_CLEAR) || (state_q == S_WRITE);
    mem_waddr = (state_q == S_CLEAR) ? clr_q : eidx_q;
    mem_wdata = (state_q == S_CLEAR) ? entry_t'('0) : fin;
    mem_raddr = (state_q == S_RDSLOT) ? AW'(slot_q) : eidx_q;
  end

  // Entry memory: one write and one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= tbl_mem[mem_raddr];
  end

  // Shared multiplier stage
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q   <= RstInvSize;
      burn_q  <= RstBurnIn;
      maxs_q  <= RstMaxStep;
      gray_q  <= RstGray;
      skipg_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgInvSize:  inv_q   <= cfg_data_i;
        CfgBurnIn:   burn_q  <= cfg_data_i[15:0];
        CfgMaxStep:  maxs_q  <= cfg_data_i[7:0];
        CfgGray:     gray_q  <= cfg_data_i[7:0];
        CfgSkipGray: skipg_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      total_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= done_d;
      unique case (state_q)
        // Sweep the table to unused
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == LastIdx) begin
            state_q <= S_IDLE;
          end
        end

        // Take a word
        S_IDLE: begin
          if (start) begin
            pos_q    <= {pos_z_i, pos_y_i, pos_x_i};
            col_q    <= {blue_in_i, green_in_i, red_in_i};
            slot_q   <= slot_i;
            newv_q   <= 1'b0;
            valid_q  <= 1'b0;
            avg_q    <= '0;
            cout_q   <= '0;
            samp_q   <= '0;
            unique case (op_i)
              OpClear: begin
                total_q  <= '0;
                status_q <= StCleared;
                clr_q    <= '0;
                state_q  <= S_CLEAR;
              end
              OpUpdate: begin
                if (gray_hit) begin
                  status_q <= StSkipped;
                end else begin
                  cnt_q   <= '0;
                  state_q <= S_QUANT;
                end
              end
              default: state_q <= S_RDSLOT;
            endcase
          end
        end

        // Read one slot
        S_RDSLOT: state_q <= S_RDDATA;
        S_RDDATA: begin
          status_q <= StRead;
          if (slot_ok && rd_q.used) begin
            valid_q <= 1'b1;
            avg_q   <= rd_q.mpos;
            cout_q  <= rd_q.est;
            samp_q  <= rd_q.samples;
          end
          state_q <= S_IDLE;
        end

        // Quantize the three axes through the multiplier
        S_QUANT: begin
          if (cnt_q != 7'd0) begin
            key_q[2'(cnt_q - 7'd1)] <= prod_q[63:32];
          end
          if (cnt_q == 7'd3) begin
            cnt_q   <= '0;
            axis_q  <= '0;
            hash_q  <= '0;
            state_q <= S_MIX;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end

        // Mix each key, nine steps per axis
        S_MIX: begin
          if (cnt_q == 7'd8) begin
            cnt_q <= '0;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
          case (cnt_q)
            7'd0: begin
              mv_q <= ({32'd0, key_q[axis_q]} + MixGolden) ^
                      (({32'd0, key_q[axis_q]} + MixGolden) >> 30);
            end
            7'd2, 7'd6: plo_q <= prod_q[63:0];
            7'd3, 7'd7: pcr_q <= prod_q[31:0];
            7'd4: mv_q <= mix_s ^ (mix_s >> 27);
            7'd8: begin
              hash_q <= hash_q ^ (mix_f << axis_q);
              axis_q <= axis_q + 2'd1;
              if (axis_q == 2'd2) begin
                modr_q  <= '0;
                state_q <= S_MOD;
              end
            end
            default: ;
          endcase
        end

        // Reduce the hash to a start slot
        S_MOD: begin
          probe_q <= '0;
          if (DepthPow2) begin
            eidx_q  <= hash_q[AW-1:0];
            state_q <= S_PRD;
          end else begin
            modr_q <= mod_t;
            hash_q <= hash_q << 1;
            cnt_q  <= cnt_q + 7'd1;
            if (cnt_q == 7'd63) begin
              eidx_q  <= mod_t[AW-1:0];
              state_q <= S_PRD;
            end
          end
        end

        // Probe one slot
        S_PRD: state_q <= S_PCHK;
        S_PCHK: begin
          if (!rd_q.used || keys_eq) begin
            fresh_q  <= !rd_q.used;
            burnin_q <= n_next <= burn_eff;
            job_q    <= '0;
            state_q  <= S_DSET;
            ent_q    <= seed;
          end else if (probe_q == LastProbe) begin
            status_q <= StFull;
            state_q  <= S_IDLE;
          end else begin
            probe_q <= probe_q + PW'(1);
            eidx_q  <= (eidx_q == LastIdx) ? '0 : eidx_q + AW'(1);
            state_q <= S_PRD;
          end
        end

        // Load the divider with |delta| + n/2
        S_DSET: begin
          neg_q   <= dset_d[32];
          num_q   <= {1'b0, dset_mag} + {3'd0, n_cur[31:1]};
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_DIV;
        end

        // Restoring division, one quotient bit a cycle
        S_DIV: begin
          rem_q <= div_ge ? 32'(div_t - {1'b0, n_cur}) : div_t[31:0];
          num_q <= {num_q[32:0], div_ge};
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd33) begin
            state_q <= S_DAPP;
          end
        end

        // Apply the rounded step to the mean
        S_DAPP: begin
          if (job_q < 3'd3) begin
            ent_q.mpos[pj] <= ent_q.mpos[pj] + adj[31:0];
          end else begin
            ent_q.mcol[cj]  <= m17[15:0];
            ent_q.est[cj]   <= est_b;
            ent_q.step[cj]  <= 8'd1;
            ent_q.trend[cj] <= TrendNone;
          end
          job_q <= job_q + 3'd1;
          if ((job_q == 3'd2 && !burnin_q) || job_q == 3'd5) begin
            state_q <= S_WRITE;
          end else begin
            state_q <= S_DSET;
          end
        end

        // Write back and report
        S_WRITE: begin
          status_q <= burnin_q ? StBurnIn : StTracked;
          newv_q   <= fresh_q;
          valid_q  <= 1'b1;
          avg_q    <= fin.mpos;
          cout_q   <= fin.est;
          samp_q   <= fin.samples;
          if (fresh_q) begin
            total_q <= total_q + CW'(1);
          end
          state_q <= S_IDLE;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Drive the result ports
  logic [31:0] total_ext;
  assign total_ext     = 32'(total_q);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign new_voxel_o   = newv_q;
  assign entry_valid_o = valid_q;
  assign avg_x_o       = avg_q[0];
  assign avg_y_o       = avg_q[1];
  assign avg_z_o       = avg_q[2];
  assign red_out_o     = cout_q[0];
  assign green_out_o   = cout_q[1];
  assign blue_out_o    = cout_q[2];
  assign samples_o     = samp_q;
  assign occupied_o    = total_ext[12:0];

endmodule

`default_nettype wire
